// ===== sv/engine_start_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Engine start sequencer assertion macros
// Shared concurrent assertion wrappers clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ENGINE_START_SEQUENCER_CORE_MACROS_SVH
`define ENGINE_START_SEQUENCER_CORE_MACROS_SVH

// Check a property on every rising edge outside reset
`define ESC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent on the next edge
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ess_pkg.sv =====
// ----------------------------------------------------------------------------
// Engine start sequencer package
// Shared types, codes and reset constants for the sequencer core.
// ----------------------------------------------------------------------------
package ess_pkg;

  localparam int unsigned TicksW   = 20;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [TicksW-1:0] SettleReset = TicksW'(3000);
  localparam logic [TicksW-1:0] CrankReset  = TicksW'(1000);
  localparam logic [TicksW-1:0] VerifyReset = TicksW'(30000);
  localparam logic [TicksW-1:0] TicksMax    = '1;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_ACTIVE    = 3'd2,
    ST_LOWBAT    = 3'd3,
    ST_INTERLOCK = 3'd4,
    ST_CHARGING  = 3'd5,
    ST_TIMEOUT   = 3'd6,
    ST_STOPPED   = 3'd7
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE = 2'd0,
    REG_CRANK  = 2'd1,
    REG_VERIFY = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] action;
    logic       handbrake_pulled;
    logic       in_neutral;
    logic       battery_low;
    logic       alternator_charging;
  } item_t;

  typedef struct packed {
    logic [TicksW-1:0] settle;
    logic [TicksW-1:0] crank;
    logic [TicksW-1:0] verify;
  } cfg_t;

  typedef struct packed {
    logic       ign_drive;
    logic       starter_drive;
    logic [2:0] status;
    logic       clear_auth;
  } result_t;

endpackage

// ===== sv/ess_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Engine start sequencer configuration registers
// Holds the settle, crank and verify tick limits written over the cfg port.
// ----------------------------------------------------------------------------
module ess_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [ess_pkg::CfgIdxW-1:0]      wr_index_i,
  input  logic [ess_pkg::TicksW-1:0]       wr_data_i,
  output ess_pkg::cfg_t                    cfg_o
);

  ess_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        ess_pkg::REG_SETTLE: cfg_d.settle = wr_data_i;
        ess_pkg::REG_CRANK:  cfg_d.crank  = wr_data_i;
        ess_pkg::REG_VERIFY: cfg_d.verify = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle <= ess_pkg::SettleReset;
      cfg_q.crank  <= ess_pkg::CrankReset;
      cfg_q.verify <= ess_pkg::VerifyReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ess_phase_fsm.sv =====
// ----------------------------------------------------------------------------
// Engine start sequencer phase machine
// Phase and tick counter state plus the per-item next-state and result logic.
// ----------------------------------------------------------------------------
module ess_phase_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  ess_pkg::item_t   item_i,
  input  ess_pkg::cfg_t    cfg_i,
  output ess_pkg::result_t result_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_CRANK   = 3'd2,
    PH_VERIFY  = 3'd3,
    PH_RUNNING = 3'd4
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [ess_pkg::TicksW-1:0]  ticks_q, ticks_d;
  logic [ess_pkg::TicksW-1:0]  ticks_inc;
  logic [2:0]                  status;
  logic                        clear;

  // Saturating tick count
  assign ticks_inc = (ticks_q == ess_pkg::TicksMax) ? ticks_q
                                                    : ticks_q + 1'b1;

  // Work out the next phase and the status for the current item
  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    status  = ess_pkg::ST_NONE;
    clear   = 1'b0;
    unique case (item_i.action)
      ess_pkg::ACT_START: begin
        priority if (phase_q != PH_IDLE) begin
          status = ess_pkg::ST_ACTIVE;
        end else if (item_i.battery_low) begin
          status = ess_pkg::ST_LOWBAT;
        end else if (!item_i.handbrake_pulled || !item_i.in_neutral) begin
          status = ess_pkg::ST_INTERLOCK;
        end else begin
          phase_d = PH_SETTLE;
          ticks_d = '0;
          status  = ess_pkg::ST_ACCEPTED;
        end
      end
      ess_pkg::ACT_STOP: begin
        phase_d = PH_IDLE;
        ticks_d = '0;
        status  = ess_pkg::ST_STOPPED;
      end
      ess_pkg::ACT_TICK: begin
        unique case (phase_q)
          PH_SETTLE: begin
            ticks_d = ticks_inc;
            if (ticks_inc >= cfg_i.settle) begin
              phase_d = PH_CRANK;
              ticks_d = '0;
            end
          end
          PH_CRANK: begin
            ticks_d = ticks_inc;
            if (ticks_inc >= cfg_i.crank) begin
              phase_d = PH_VERIFY;
              ticks_d = '0;
            end
          end
          PH_VERIFY: begin
            // Charging wins over the timeout on the same tick
            if (item_i.alternator_charging) begin
              phase_d = PH_RUNNING;
              ticks_d = '0;
              status  = ess_pkg::ST_CHARGING;
            end else begin
              ticks_d = ticks_inc;
              if (ticks_inc >= cfg_i.verify) begin
                phase_d = PH_IDLE;
                ticks_d = '0;
                status  = ess_pkg::ST_TIMEOUT;
                clear   = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Hold state; advance only on a transfer into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ticks_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

  assign result_o.ign_drive     = (phase_d != PH_IDLE);
  assign result_o.starter_drive = (phase_d == PH_CRANK);
  assign result_o.status        = status;
  assign result_o.clear_auth    = clear;

endmodule

// ===== sv/engine_start_sequencer_core.sv =====
// An item passes from the input register into the result register, which drives the output.
// Throughput: one item per clock while out_stall_i is low; the input register and
//   result register let a new item enter while a finished result waits to be taken.
// The single phase register and its saturating tick counter set the pace.
// Reset: asynchronous, active low; phase goes idle, tick count clears, the tick
//   limits return to 3000, 1000 and 30000, and both pipeline slots empty.
// ----------------------------------------------------------------------------
// Engine start sequencer core
// Remote start sequencing of ignition, starter and alternator check per tick.
// ----------------------------------------------------------------------------
module engine_start_sequencer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Item input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic                         handbrake_pulled_i,
  input  logic                         in_neutral_i,
  input  logic                         battery_low_i,
  input  logic                         alternator_charging_i,
  // Result output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ign_drive_o,
  output logic                         starter_drive_o,
  output logic [2:0]                   status_o,
  output logic                         clear_auth_o,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ess_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ess_pkg::TicksW-1:0]   cfg_data_i
);

  ess_pkg::cfg_t    cfg;
  ess_pkg::item_t   item_q;
  ess_pkg::result_t res_next, res_q;
  logic             in_valid_q, out_valid_q;
  logic             out_free, fire, in_take;

  // Configuration is always writable
  assign cfg_ready_o = 1'b1;

  ess_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register: control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action              <= action_i;
      item_q.handbrake_pulled    <= handbrake_pulled_i;
      item_q.in_neutral          <= in_neutral_i;
      item_q.battery_low         <= battery_low_i;
      item_q.alternator_charging <= alternator_charging_i;
    end
  end

  ess_phase_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_next)
  );

  // Result register: control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ign_drive_o     = res_q.ign_drive;
  assign starter_drive_o = res_q.starter_drive;
  assign status_o        = res_q.status;
  assign clear_auth_o    = res_q.clear_auth;

endmodule

// ===== sv/ess_checker.sv =====
// ----------------------------------------------------------------------------
// Engine start sequencer port checker
// Watches the top-level ports for relay and status consistency.
// ----------------------------------------------------------------------------
`include "engine_start_sequencer_core_macros.svh"

module ess_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       ign_drive_o,
  input logic       starter_drive_o,
  input logic [2:0] status_o,
  input logic       clear_auth_o
);

  logic starter_ok, clear_ok, stop_ok, accept_ok;

  // Relay and status combinations a result may show
  assign starter_ok = !starter_drive_o || ign_drive_o;
  assign clear_ok   = !clear_auth_o || (status_o == ess_pkg::ST_TIMEOUT && !ign_drive_o);
  assign stop_ok    = status_o != ess_pkg::ST_STOPPED || (!ign_drive_o && !starter_drive_o);
  assign accept_ok  = status_o != ess_pkg::ST_ACCEPTED || (ign_drive_o && !starter_drive_o);

  // Starter never runs without ignition
  `ESC_ASSERT(a_starter_needs_ign, !out_valid_o || starter_ok, "starter without ignition")

  // Clear-authorization pulses only on a timeout with relays off
  `ESC_ASSERT(a_clear_on_timeout, !out_valid_o || clear_ok, "clear_auth outside timeout")

  // A stop leaves both relays off
  `ESC_ASSERT(a_stop_relays_off, !out_valid_o || stop_ok, "relays on after stop")

  // An accepted start shows ignition on and the starter off
  `ESC_ASSERT(a_accept_settle, !out_valid_o || accept_ok, "bad relays after accepted start")

  // A stalled result stays offered
  `ESC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o), "stalled result dropped")

endmodule

bind engine_start_sequencer_core ess_checker u_ess_checker (.*);

// ===== tb/engine_start_sequencer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Engine start sequencer core testbench
// Drives ticks, start and stop requests with random flags through the item
// channel and checks each reported relay state against a local predictor of
// the phase sequence, across several tick-limit settings and idle patterns.
// ----------------------------------------------------------------------------
module engine_start_sequencer_core_tb;
  import ess_pkg::*;

  localparam int unsigned        CycleLimit  = 500000;
  localparam logic [1:0]         ActReserved = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused   = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_CRANK   = 3'd2,
    PH_VERIFY  = 3'd3,
    PH_RUNNING = 3'd4
  } phase_e;

  logic               clk_i                 = 1'b0;
  logic               rst_ni                = 1'b0;
  logic               in_valid_i            = 1'b0;
  logic               in_stall_o;
  logic [1:0]         action_i              = '0;
  logic               handbrake_pulled_i    = 1'b0;
  logic               in_neutral_i          = 1'b0;
  logic               battery_low_i         = 1'b0;
  logic               alternator_charging_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i           = 1'b0;
  logic               ign_drive_o;
  logic               starter_drive_o;
  logic [2:0]         status_o;
  logic               clear_auth_o;
  logic               cfg_valid_i           = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i           = '0;
  logic [TicksW-1:0]  cfg_data_i            = '0;

  // Predictor state: tick limits, phase and tick count
  logic [TicksW-1:0] settle_lim  = SettleReset;
  logic [TicksW-1:0] crank_lim   = CrankReset;
  logic [TicksW-1:0] verify_lim  = VerifyReset;
  phase_e            seq_phase   = PH_IDLE;
  logic [TicksW-1:0] phase_ticks = '0;

  result_t     pending_reports[$];
  int          failures        = 0;
  int          effective_items = 0;
  int          sender_idle_pct = 0;
  int          stall_pct       = 0;
  int unsigned cycle_count     = 0;

  engine_start_sequencer_core uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .action_i              (action_i),
    .handbrake_pulled_i    (handbrake_pulled_i),
    .in_neutral_i          (in_neutral_i),
    .battery_low_i         (battery_low_i),
    .alternator_charging_i (alternator_charging_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .ign_drive_o           (ign_drive_o),
    .starter_drive_o       (starter_drive_o),
    .status_o              (status_o),
    .clear_auth_o          (clear_auth_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL engine_start_sequencer_core");
      $finish;
    end
  end

  // Stall the result channel at the current rate
  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Random single flag
  function automatic logic rand_bit();
    return $urandom_range(1) == 1;
  endfunction

  // Saturating tick count in the current phase
  function automatic void advance_ticks();
    if (phase_ticks != TicksMax) phase_ticks = phase_ticks + 1'b1;
  endfunction

  // Step the sequencer model by one item and return the relay report
  function automatic result_t predict_relays(item_t it);
    result_t rep;
    rep = '0;
    rep.status = ST_NONE;
    case (it.action)
      ACT_START: begin
        if (seq_phase != PH_IDLE) begin
          rep.status = ST_ACTIVE;
        end else if (it.battery_low) begin
          rep.status = ST_LOWBAT;
        end else if (!it.handbrake_pulled || !it.in_neutral) begin
          rep.status = ST_INTERLOCK;
        end else begin
          seq_phase   = PH_SETTLE;
          phase_ticks = '0;
          rep.status  = ST_ACCEPTED;
        end
      end
      ACT_STOP: begin
        seq_phase   = PH_IDLE;
        phase_ticks = '0;
        rep.status  = ST_STOPPED;
      end
      ACT_TICK: begin
        case (seq_phase)
          PH_SETTLE: begin
            advance_ticks();
            if (phase_ticks >= settle_lim) begin
              seq_phase   = PH_CRANK;
              phase_ticks = '0;
            end
          end
          PH_CRANK: begin
            advance_ticks();
            if (phase_ticks >= crank_lim) begin
              seq_phase   = PH_VERIFY;
              phase_ticks = '0;
            end
          end
          PH_VERIFY: begin
            // Charging wins over a timeout on the same tick
            if (it.alternator_charging) begin
              seq_phase   = PH_RUNNING;
              phase_ticks = '0;
              rep.status  = ST_CHARGING;
            end else begin
              advance_ticks();
              if (phase_ticks >= verify_lim) begin
                seq_phase      = PH_IDLE;
                phase_ticks    = '0;
                rep.status     = ST_TIMEOUT;
                rep.clear_auth = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    rep.ign_drive     = (seq_phase != PH_IDLE);
    rep.starter_drive = (seq_phase == PH_CRANK);
    return rep;
  endfunction

  task automatic report_field(string name, logic [2:0] want, logic [2:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Compare each result transfer with the oldest pending report
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with no pending report");
        failures++;
      end else begin
        want = pending_reports.pop_front();
        report_field("ign_drive", want.ign_drive, ign_drive_o);
        report_field("starter_drive", want.starter_drive, starter_drive_o);
        report_field("status", want.status, status_o);
        report_field("clear_auth", want.clear_auth, clear_auth_o);
      end
    end
  end

  // Send one item after a random gap and record its predicted report
  task automatic send_item(logic [1:0] act, logic hb, logic neu, logic lowbat,
                           logic chg);
    item_t it;
    int    gap;
    it  = '{action: act, handbrake_pulled: hb, in_neutral: neu,
            battery_low: lowbat, alternator_charging: chg};
    gap = 0;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i            <= 1'b1;
    action_i              <= it.action;
    handbrake_pulled_i    <= it.handbrake_pulled;
    in_neutral_i          <= it.in_neutral;
    battery_low_i         <= it.battery_low;
    alternator_charging_i <= it.alternator_charging;
    do @(posedge clk_i); while (in_stall_o);
    // Ignored items do not count toward the traffic quota
    if (act != ActReserved &&
        !(act == ACT_TICK && (seq_phase == PH_IDLE || seq_phase == PH_RUNNING)))
      effective_items++;
    pending_reports.push_back(predict_relays(it));
  endtask

  task automatic send_tick(logic chg);
    send_item(ACT_TICK, rand_bit(), rand_bit(), rand_bit(), chg);
  endtask

  // Hold the item channel idle until every report has come back
  task automatic wait_reports_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_register(logic [CfgIdxW-1:0] idx, logic [TicksW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SETTLE: settle_lim = value;
      REG_CRANK:  crank_lim  = value;
      REG_VERIFY: verify_lim = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_limits(logic [TicksW-1:0] settle, logic [TicksW-1:0] crank,
                                logic [TicksW-1:0] verify);
    wait_reports_done();
    program_register(REG_SETTLE, settle);
    program_register(REG_CRANK, crank);
    program_register(REG_VERIFY, verify);
  endtask

  // Start under the reset limits; ignition holds through early settling
  task automatic test_reset_defaults();
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    repeat (40) send_tick(1'b0);
    send_item(ACT_STOP, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // Every action, refusal order and phase transition with short limits
  task automatic test_directed_cases();
    program_limits(TicksW'(2), TicksW'(1), TicksW'(2));
    send_item(ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(ActReserved, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(ACT_STOP, 1'b0, 1'b0, 1'b0, 1'b0);
    // Low battery is reported ahead of the interlocks
    send_item(ACT_START, 1'b1, 1'b1, 1'b1, 1'b0);
    send_item(ACT_START, 1'b0, 1'b0, 1'b1, 1'b0);
    send_item(ACT_START, 1'b0, 1'b1, 1'b0, 1'b0);
    send_item(ACT_START, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b1);
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1);
    send_item(ACT_STOP, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    // Busy while cranking, reserved action ignored
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(ActReserved, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0);
    send_item(ACT_STOP, 1'b0, 1'b0, 1'b1, 1'b1);
    // Charging never shows: timeout and clear pulse
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    repeat (3) send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Zero limits act as one tick; unused index; all-ones limits
  task automatic test_register_extremes();
    program_limits('0, '0, '0);
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_item(ACT_STOP, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_reports_done();
    program_register(RegUnused, '1);
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    program_limits(TicksMax, TicksMax, TicksMax);
    send_item(ACT_START, 1'b1, 1'b1, 1'b0, 1'b0);
    repeat (3) send_tick(1'b1);
    send_item(ACT_STOP, 1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  // Mostly complete start sequences with random content, plus noise
  task automatic test_random_traffic(int idle_pct, int stall_rate, int quota);
    int target;
    int span;
    int r;
    bit paused;
    program_limits(TicksW'($urandom_range(4, 1)), TicksW'($urandom_range(4, 1)),
                   TicksW'($urandom_range(6, 1)));
    sender_idle_pct = idle_pct;
    stall_pct       = stall_rate;
    target          = effective_items + quota;
    paused          = 1'b0;
    while (effective_items < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_item(ACT_START, 1'b1, 1'b1, 1'b0, rand_bit());
        span = $urandom_range(int'(settle_lim + crank_lim + verify_lim) + 2, 1);
        repeat (span) begin
          if ($urandom_range(29) == 0)
            send_item(ACT_START, rand_bit(), rand_bit(), rand_bit(), rand_bit());
          else
            send_tick($urandom_range(7) == 0);
        end
        if (rand_bit()) send_item(ACT_STOP, rand_bit(), rand_bit(), rand_bit(),
                                  rand_bit());
      end else if (r < 85) begin
        send_item(ACT_START, rand_bit(), rand_bit(), rand_bit(), rand_bit());
      end else begin
        send_item(2'($urandom_range(3)), rand_bit(), rand_bit(), rand_bit(),
                  rand_bit());
      end
      // Hold the sender once mid-phase until all reports drain
      if (!paused && effective_items >= target - quota / 2) begin
        wait_reports_done();
        paused = 1'b1;
      end
    end
    wait_reports_done();
    sender_idle_pct = 0;
    stall_pct       = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed_cases();
    test_register_extremes();
    test_random_traffic(0, 0, 300);
    test_random_traffic(88, 0, 300);
    test_random_traffic(0, 88, 300);
    test_random_traffic(6, 6, 300);
    wait_reports_done();
    repeat (4) @(posedge clk_i);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("PASS engine_start_sequencer_core");
    end else begin
      $display("FAIL engine_start_sequencer_core");
    end
    $finish;
  end

endmodule
